>>> rtl/core/battery_charge_tracker_unit_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the charge tracker
// Clocked on clk, disabled while rst is high.
// ---------------------------------------------------------------------------
`ifndef BATTERY_CHARGE_TRACKER_UNIT_MACROS_SVH
`define BATTERY_CHARGE_TRACKER_UNIT_MACROS_SVH

// same-cycle implication
`define BCT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BCT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/bct_pkg.sv
// ---------------------------------------------------------------------------
// bct_pkg
// Types and constants shared by the charge tracker modules.
// ---------------------------------------------------------------------------
package bct_pkg;

  localparam int CHARGE_W   = 31;
  localparam int PRED_W     = 32;
  localparam int FEEDBACK_W = 33;
  localparam int INDEX_W    = 16;
  localparam int PERCENT_W  = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;

  // shared divider: dividend covers charge * 100, divisor covers charge
  localparam int DIV_NUM_W = 38;
  localparam int DIV_DEN_W = 31;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INDEX_MIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INDEX_MAX = 2'd2;

  localparam logic [CHARGE_W-1:0]  CAPACITY_RESET  = 31'd2000;
  localparam logic signed [INDEX_W-1:0] INDEX_MIN_RESET = -16'sd100;
  localparam logic signed [INDEX_W-1:0] INDEX_MAX_RESET = 16'sd100;
  localparam logic [CHARGE_W-1:0]  CHARGE_MAX      = 31'h7FFF_FFFF;
  localparam logic [PERCENT_W-1:0] PERCENT_SCALE   = 7'd100;

  typedef struct packed {
    logic [CHARGE_W-1:0]      charge_reading;
    logic signed [PRED_W-1:0] predicted_delta;
    logic [CHARGE_W-1:0]      expected_lifetime;
  } in_item_t;

  typedef struct packed {
    logic signed [FEEDBACK_W-1:0] power_feedback;
    logic signed [INDEX_W-1:0]    power_index;
    logic                         depleted;
    logic [CHARGE_W-1:0]          average_charge;
    logic [CHARGE_W-1:0]          remaining_charge;
    logic [PERCENT_W-1:0]         remaining_percent;
  } out_item_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] dividend;
    logic [DIV_DEN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [DIV_NUM_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LAUNCH_IDX,
    ST_WAIT_IDX,
    ST_LAUNCH_AVG,
    ST_WAIT_AVG,
    ST_MUL,
    ST_LAUNCH_PCT,
    ST_WAIT_PCT,
    ST_FINISH
  } state_t;

endpackage

>>> rtl/core/bct_stream_if.sv
// ---------------------------------------------------------------------------
// bct_stream_if
// Valid/ready channel carrying one payload item per transfer.
// ---------------------------------------------------------------------------
interface bct_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/core/bct_divider.sv
// ---------------------------------------------------------------------------
// bct_divider
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// ---------------------------------------------------------------------------
module bct_divider import bct_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_NUM_W-1:0] quo;
  logic [DIV_DEN_W-1:0] den;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;
  logic [DIV_DEN_W:0]   shifted;
  logic                 fits;
  logic [DIV_DEN_W:0]   trial;

  assign shifted = {rem, quo[DIV_NUM_W-1]};
  assign trial   = shifted - {1'b0, den};
  assign fits    = shifted >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.dividend;
      den <= req.divisor;
    end else if (busy) begin
      rem <= fits ? trial[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
      quo <= {quo[DIV_NUM_W-2:0], fits};
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

>>> rtl/core/battery_charge_tracker_unit.sv
// ---------------------------------------------------------------------------
// battery_charge_tracker_unit
// Coulomb-counter fuel gauge with a running average of the readings.
// ---------------------------------------------------------------------------
// Use: one transfer on in_ch per activation brings the cumulative charge
// reading, the predicted delta and the required lifetime. One transfer on
// out_ch returns feedback, power index, depletion flag, average, remaining
// charge and remaining percent.
// Sequence: a division for the power index, one for the average, a multiply
// of the remaining charge by 100 and a division for the percent, all on one
// shared restoring divider, then a load of the output register. in_ch.ready
// is high only while no item is in work, so a new item is taken only after
// the last result has gone into the output register.
// A result waits in the output register while out_ch.ready is low; the next
// item is taken meanwhile, and its result is held back until the register
// is free.
// Reset: capacity 2000, clamps -100/100, remaining charge = capacity, average
// store empty. Writing the capacity (cfg_index 0) reloads remaining charge and
// empties that store. Writes must be made only while idle; the block does not enforce it.
// ---------------------------------------------------------------------------
`include "battery_charge_tracker_unit_macros.svh"

module battery_charge_tracker_unit import bct_pkg::*; #(
  parameter int AVG_DEPTH = 5
) (
  input  logic                  clk,
  input  logic                  rst,
  bct_stream_if.sink            in_ch,
  bct_stream_if.source          out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int POS_W   = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int CNT_W   = $clog2(AVG_DEPTH + 1);
  localparam int TOTAL_W = CHARGE_W + $clog2(AVG_DEPTH);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(AVG_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(AVG_DEPTH);

  state_t state, state_next;

  logic [CHARGE_W-1:0]        capacity;
  logic signed [INDEX_W-1:0]  index_min;
  logic signed [INDEX_W-1:0]  index_max;
  logic [CHARGE_W-1:0]        last_reading;
  logic [CHARGE_W-1:0]        charge_left;
  logic [CHARGE_W-1:0]        window_store [AVG_DEPTH];
  logic [AVG_DEPTH-1:0]       window_valid;
  logic [POS_W-1:0]           window_pos;
  logic                       window_full;
  logic [TOTAL_W-1:0]         window_total;

  logic signed [PRED_W-1:0]     delta;
  logic signed [FEEDBACK_W-1:0] feedback;
  logic                         depleted;
  logic [CHARGE_W-1:0]          lifetime;
  logic [CNT_W-1:0]             count;
  logic signed [INDEX_W-1:0]    index_res;
  logic [CHARGE_W-1:0]          average_res;
  logic [PERCENT_W-1:0]         percent_res;
  logic [DIV_NUM_W-1:0]         product;

  div_req_t div_req;
  div_rsp_t div_rsp;

  in_item_t  in_item;
  out_item_t out_item;

  logic                     accept;
  logic signed [PRED_W-1:0] delta_next;
  logic [FEEDBACK_W-1:0]    diff;
  logic                     left_gt;
  logic [CHARGE_W-1:0]      old_entry;
  logic [POS_W-1:0]         pos_next;
  logic                     full_next;
  logic [TOTAL_W-1:0]       total_next;
  logic signed [FEEDBACK_W-1:0] index_raw;
  logic signed [FEEDBACK_W-1:0] index_lo;
  logic signed [FEEDBACK_W-1:0] index_clamped;
  logic                     out_free;

  assign in_item = in_ch.payload;
  assign accept  = in_ch.valid && in_ch.ready;
  assign out_free = !out_ch.valid || out_ch.ready;

  // per-item front arithmetic
  assign delta_next = $signed({1'b0, in_item.charge_reading})
                    - $signed({1'b0, last_reading});
  assign left_gt    = $signed({2'b00, charge_left}) > $signed({delta_next[PRED_W-1], delta_next});
  assign diff       = {2'b00, charge_left} - {delta_next[PRED_W-1], delta_next};
  assign old_entry  = window_valid[window_pos] ? window_store[window_pos] : '0;
  assign pos_next   = (window_pos == POS_LAST) ? '0 : window_pos + 1'b1;
  assign full_next  = window_full || (window_pos == POS_LAST);
  assign total_next = window_total + TOTAL_W'(in_item.charge_reading) - TOTAL_W'(old_entry);

  // power index clamp
  assign index_raw = $signed({2'b00, div_rsp.quotient[CHARGE_W-1:0]})
                   - $signed({2'b00, lifetime});
  assign index_lo  = (index_raw < FEEDBACK_W'(index_min)) ? FEEDBACK_W'(index_min) : index_raw;
  assign index_clamped = (index_lo > FEEDBACK_W'(index_max)) ? FEEDBACK_W'(index_max) : index_lo;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:       if (in_ch.valid) state_next = ST_LAUNCH_IDX;
      ST_LAUNCH_IDX: state_next = ST_WAIT_IDX;
      ST_WAIT_IDX:   if (div_rsp.done) state_next = ST_LAUNCH_AVG;
      ST_LAUNCH_AVG: state_next = ST_WAIT_AVG;
      ST_WAIT_AVG:   if (div_rsp.done) state_next = ST_MUL;
      ST_MUL:        state_next = ST_LAUNCH_PCT;
      ST_LAUNCH_PCT: state_next = ST_WAIT_PCT;
      ST_WAIT_PCT:   if (div_rsp.done) state_next = ST_FINISH;
      ST_FINISH:     if (out_free) state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready      = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = {{(DIV_NUM_W-CHARGE_W){1'b0}}, charge_left};
    div_req.divisor  = delta[DIV_DEN_W-1:0];
    unique case (state)
      ST_IDLE:       in_ch.ready = 1'b1;
      ST_LAUNCH_IDX: div_req.start = 1'b1;
      ST_LAUNCH_AVG: begin
        div_req.start    = 1'b1;
        div_req.dividend = {{(DIV_NUM_W-TOTAL_W){1'b0}}, window_total};
        div_req.divisor  = {{(DIV_DEN_W-CNT_W){1'b0}}, count};
      end
      ST_LAUNCH_PCT: begin
        div_req.start    = 1'b1;
        div_req.dividend = product;
        div_req.divisor  = capacity;
      end
      default: begin
      end
    endcase
  end

  bct_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // configuration and tracker state
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity     <= CAPACITY_RESET;
      index_min    <= INDEX_MIN_RESET;
      index_max    <= INDEX_MAX_RESET;
      last_reading <= '0;
      charge_left  <= CAPACITY_RESET;
      window_valid <= '0;
      window_pos   <= '0;
      window_full  <= 1'b0;
      window_total <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CAPACITY: begin
          capacity     <= cfg_data;
          charge_left  <= cfg_data;
          window_valid <= '0;
          window_pos   <= '0;
          window_full  <= 1'b0;
          window_total <= '0;
        end
        REG_INDEX_MIN: index_min <= cfg_data[INDEX_W-1:0];
        REG_INDEX_MAX: index_max <= cfg_data[INDEX_W-1:0];
        default: begin
        end
      endcase
    end else if (accept) begin
      last_reading             <= in_item.charge_reading;
      if (left_gt) begin
        charge_left <= (diff[FEEDBACK_W-1:CHARGE_W] != '0) ? CHARGE_MAX : diff[CHARGE_W-1:0];
      end
      window_valid[window_pos] <= 1'b1;
      window_pos               <= pos_next;
      window_full              <= full_next;
      window_total             <= total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      window_store[window_pos] <= in_item.charge_reading;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (accept) begin
      delta    <= delta_next;
      feedback <= $signed({delta_next[PRED_W-1], delta_next})
                - $signed({in_item.predicted_delta[PRED_W-1], in_item.predicted_delta});
      depleted <= !left_gt;
      lifetime <= in_item.expected_lifetime;
      count    <= full_next ? CNT_FULL : CNT_W'(pos_next);
    end
    if (state == ST_WAIT_IDX && div_rsp.done) begin
      index_res <= (delta <= 0) ? index_max : index_clamped[INDEX_W-1:0];
    end
    if (state == ST_WAIT_AVG && div_rsp.done) begin
      average_res <= div_rsp.quotient[CHARGE_W-1:0];
    end
    if (state == ST_MUL) begin
      product <= DIV_NUM_W'(charge_left) * DIV_NUM_W'(PERCENT_SCALE);
    end
    if (state == ST_WAIT_PCT && div_rsp.done) begin
      if (capacity == '0) begin
        percent_res <= '0;
      end else if (div_rsp.quotient > DIV_NUM_W'(PERCENT_SCALE)) begin
        percent_res <= PERCENT_SCALE;
      end else begin
        percent_res <= div_rsp.quotient[PERCENT_W-1:0];
      end
    end
  end

  // output register
  always_comb begin
    out_item.power_feedback    = feedback;
    out_item.power_index       = index_res;
    out_item.depleted          = depleted;
    out_item.average_charge    = average_res;
    out_item.remaining_charge  = charge_left;
    out_item.remaining_percent = percent_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (state == ST_FINISH && out_free) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) begin
      out_ch.payload <= out_item;
    end
  end

  `BCT_ASSERT_IMPL(a_pct_range, out_ch.valid,
    out_ch.payload.remaining_percent <= PERCENT_SCALE, "remaining percent above 100")
  `BCT_ASSERT_IMPL(a_div_idle_start, div_req.start, !div_rsp.busy,
    "divider started while busy")
  `BCT_ASSERT_NEXT(a_accept_busy, accept, !in_ch.ready,
    "second transfer taken while an item is in work")
  `BCT_ASSERT_IMPL(a_index_clamp, out_ch.valid && (index_min <= index_max),
    (out_ch.payload.power_index <= index_max), "power index above upper clamp")

endmodule

>>> bench/tb_battery_charge_tracker_unit.sv
// ---------------------------------------------------------------------------
// tb_battery_charge_tracker_unit
// Self-checking bench for the charge tracker. A predictor inside a small
// class follows every accepted reading and queues the expected report;
// each report taken from out_ch is compared field by field. Directed
// readings cover depletion edges, negative and zero deltas and feedback
// extremes, then six randomised phases run under different capacities and
// clamps, with random idling on both channels and one long output hold.
// ---------------------------------------------------------------------------
module tb_battery_charge_tracker_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import bct_pkg::*;

  localparam int    WINDOW_DEPTH = 5;
  localparam longint READING_MAX = 64'h7FFF_FFFF;

  class gauge_predictor;
    longint    capacity;
    longint    clamp_lo;
    longint    clamp_hi;
    longint    last_reading;
    longint    charge_left;
    longint    window[WINDOW_DEPTH];
    int        window_pos;
    bit        window_full;
    longint    window_sum;
    out_item_t awaited_reports[$];
    int        mismatches;

    function void clear_window();
      foreach (window[i]) window[i] = 0;
      window_pos  = 0;
      window_full = 1'b0;
      window_sum  = 0;
    endfunction

    function void reset_state();
      capacity     = longint'(CAPACITY_RESET);
      clamp_lo     = longint'(INDEX_MIN_RESET);
      clamp_hi     = longint'(INDEX_MAX_RESET);
      last_reading = 0;
      charge_left  = longint'(CAPACITY_RESET);
      mismatches   = 0;
      clear_window();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_CAPACITY) begin
        capacity    = longint'(data);
        charge_left = longint'(data);
        clear_window();
      end else if (idx == REG_INDEX_MIN) begin
        clamp_lo = longint'($signed(data[INDEX_W-1:0]));
      end else if (idx == REG_INDEX_MAX) begin
        clamp_hi = longint'($signed(data[INDEX_W-1:0]));
      end
    endfunction

    function void take_reading(in_item_t it);
      longint    reading, predicted, lifetime, delta, left, oldest, fill, pidx, pct;
      longint    fb, avg;
      out_item_t rep;
      reading   = longint'(it.charge_reading);
      predicted = longint'($signed(it.predicted_delta));
      lifetime  = longint'(it.expected_lifetime);
      delta     = reading - last_reading;
      left      = charge_left;
      rep       = '0;
      if (left > delta) begin
        left = left - delta;
        if (left > READING_MAX) left = READING_MAX;
        charge_left = left;
      end else begin
        rep.depleted = 1'b1;
      end

      oldest = window[window_pos];
      window[window_pos] = reading;
      window_pos++;
      if (window_pos >= WINDOW_DEPTH) begin
        window_pos  = 0;
        window_full = 1'b1;
      end
      window_sum = window_sum + reading - oldest;
      fill = window_full ? WINDOW_DEPTH : window_pos;

      if (delta <= 0) begin
        pidx = clamp_hi;
      end else begin
        pidx = charge_left / delta - lifetime;
        if (pidx < clamp_lo) pidx = clamp_lo;
        if (pidx > clamp_hi) pidx = clamp_hi;
      end

      if (capacity == 0) begin
        pct = 0;
      end else begin
        pct = charge_left * 100 / capacity;
        if (pct > 100) pct = 100;
      end

      last_reading          = reading;
      fb                    = delta - predicted;
      avg                   = window_sum / fill;
      rep.power_feedback    = fb[FEEDBACK_W-1:0];
      rep.power_index       = pidx[INDEX_W-1:0];
      rep.average_charge    = avg[CHARGE_W-1:0];
      rep.remaining_charge  = charge_left[CHARGE_W-1:0];
      rep.remaining_percent = pct[PERCENT_W-1:0];
      awaited_reports.push_back(rep);
    endfunction

    task flag_mismatch(string what);
      mismatches++;
      $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    task match_report(out_item_t got);
      out_item_t want;
      if (awaited_reports.size() == 0) begin
        flag_mismatch("report with none outstanding");
      end else begin
        want = awaited_reports.pop_front();
        if (got.power_feedback !== want.power_feedback)
          flag_mismatch($sformatf("power_feedback %0d, want %0d",
                                  got.power_feedback, want.power_feedback));
        if (got.power_index !== want.power_index)
          flag_mismatch($sformatf("power_index %0d, want %0d",
                                  got.power_index, want.power_index));
        if (got.depleted !== want.depleted)
          flag_mismatch($sformatf("depleted %0b, want %0b", got.depleted, want.depleted));
        if (got.average_charge !== want.average_charge)
          flag_mismatch($sformatf("average_charge %0d, want %0d",
                                  got.average_charge, want.average_charge));
        if (got.remaining_charge !== want.remaining_charge)
          flag_mismatch($sformatf("remaining_charge %0d, want %0d",
                                  got.remaining_charge, want.remaining_charge));
        if (got.remaining_percent !== want.remaining_percent)
          flag_mismatch($sformatf("remaining_percent %0d, want %0d",
                                  got.remaining_percent, want.remaining_percent));
      end
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bct_stream_if #(.payload_t(in_item_t))  in_ch ();
  bct_stream_if #(.payload_t(out_item_t)) out_ch ();

  battery_charge_tracker_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  gauge_predictor gauge;
  int     tx_idle_pct;
  int     rx_idle_pct;
  bit     hold_go;
  logic   hold_active;
  longint prev_reading;
  longint cur_capacity;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

  // long output hold-off, so the block backs up and stalls in_ch
  initial begin
    hold_active = 1'b0;
    wait (hold_go);
    @(posedge clk);
    hold_active <= 1'b1;
    repeat (800) @(posedge clk);
    hold_active <= 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) gauge.match_report(out_ch.payload);
    if (hold_active) out_ch.ready <= 1'b0;
    else             out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  task automatic offer(input longint r, input longint p, input longint l);
    in_item_t it;
    it.charge_reading    = r[CHARGE_W-1:0];
    it.predicted_delta   = p[PRED_W-1:0];
    it.expected_lifetime = l[CHARGE_W-1:0];
    prev_reading         = longint'(it.charge_reading);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= it;
    do @(posedge clk); while (!in_ch.ready);
    gauge.take_reading(it);
  endtask

  task automatic wait_all_reported();
    in_ch.valid <= 1'b0;
    while (gauge.awaited_reports.size() != 0) @(posedge clk);
  endtask

  task automatic configure(input longint cap, input logic signed [INDEX_W-1:0] lo,
                           input logic signed [INDEX_W-1:0] hi);
    wait_all_reported();
    repeat (8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_CAPACITY;
    cfg_data  <= cap[CFG_DATA_W-1:0];
    @(posedge clk);
    gauge.write_reg(REG_CAPACITY, cap[CFG_DATA_W-1:0]);
    cfg_index <= REG_INDEX_MIN;
    cfg_data  <= {{(CFG_DATA_W-INDEX_W){1'b0}}, lo};
    @(posedge clk);
    gauge.write_reg(REG_INDEX_MIN, {{(CFG_DATA_W-INDEX_W){1'b0}}, lo});
    cfg_index <= REG_INDEX_MAX;
    cfg_data  <= {{(CFG_DATA_W-INDEX_W){1'b0}}, hi};
    @(posedge clk);
    gauge.write_reg(REG_INDEX_MAX, {{(CFG_DATA_W-INDEX_W){1'b0}}, hi});
    cfg_we       <= 1'b0;
    cur_capacity  = cap;
  endtask

  initial begin
    longint r, p, l, step, span;
    int     mode;
    logic signed [INDEX_W-1:0] lo, hi;

    gauge = new();
    gauge.reset_state();
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_index      = REG_CAPACITY;
    cfg_data       = '0;
    in_ch.valid    = 1'b0;
    in_ch.payload  = '0;
    hold_go        = 1'b0;
    tx_idle_pct    = 19;
    rx_idle_pct    = 63;
    prev_reading   = 0;
    cur_capacity   = longint'(CAPACITY_RESET);
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: zero, negative and boundary deltas at reset settings
    offer(0, 0, 0);
    offer(100, 100, 0);
    offer(100, -5, 3);
    offer(50, 7, 0);
    offer(2000, 1950, 0);           // remaining equals delta: depleted
    offer(3949, 0, 0);              // leaves exactly one unit
    offer(3950, 0, 0);
    offer(3951, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    offer(3951, 32'h8000_0000, 0);
    offer(0, 32'h7FFF_FFFF, 0);
    offer(32'h7FFF_FFFF, 32'h8000_0000, 0);   // largest feedback
    offer(0, 32'h7FFF_FFFF, 0);     // remaining saturates
    offer(1, 0, 0);                 // index clamps high
    offer(1, 0, 32'h7FFF_FFFF);
    offer(1001, 1000, 10);
    offer(1002, 0, 1);
    offer(32'h7FFF_FFFE, -1, 5);
    offer(32'h7FFF_FFFD, 0, 0);
    offer(32'h7FFF_FFFD, 32'h5555_5555, 31'h2AAA_AAAA);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: configure(2000, -16'sd100, 16'sd100);
        1: configure(1, -16'sd32768, 16'sd32767);
        2: configure(64'h7FFF_FFFF, 16'sd32767, -16'sd32768);   // crossed clamps
        3: begin
          lo = INDEX_W'($urandom);
          hi = INDEX_W'($urandom);
          configure(longint'($urandom_range(1, 1000000)), lo, hi);
        end
        4: configure(100000, -16'sd1000, 16'sd1000);
        default: configure(5000, 16'sd0, 16'sd0);
      endcase
      if (ph < 2) begin
        tx_idle_pct = 19;
        rx_idle_pct = 63;
      end else if (ph < 4) begin
        tx_idle_pct = 63;
        rx_idle_pct = 19;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if (ph == 4) hold_go = 1'b1;

      for (int n = 0; n < 300; n++) begin
        if (ph == 5 && n == 150) wait_all_reported();
        mode = $urandom_range(99);
        if (mode < 70) begin
          span = cur_capacity / 25;
          if (span < 1) span = 1;
          step = longint'($urandom_range(0, 32'(span)));
          r = prev_reading + step;
          if (r > READING_MAX) r = step;
          p = step + longint'($urandom_range(0, 20)) - 10;
          l = longint'($urandom_range(0, 150));
        end else if (mode < 80) begin
          span = cur_capacity / 50 + 1;
          if (span > prev_reading) span = prev_reading;
          r = prev_reading - longint'($urandom_range(0, 32'(span)));
          p = longint'($signed($urandom));
          l = longint'($urandom_range(0, 150));
        end else if (mode < 88) begin
          r = prev_reading;
          p = longint'($urandom_range(0, 6)) - 3;
          l = longint'($urandom_range(0, 50));
        end else begin
          r = $urandom & READING_MAX;
          p = longint'($signed($urandom));
          l = $urandom & READING_MAX;
        end
        offer(r, p, l);
      end
    end

    wait_all_reported();
    repeat (200) @(posedge clk);
    if (gauge.mismatches == 0 && gauge.awaited_reports.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
